// ----- src/path_resampler_fixed_step_assert.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the fixed-step path resampler
// Property helpers for same-cycle and next-cycle implications.
// ---------------------------------------------------------------------------
`ifndef PATH_RESAMPLER_FIXED_STEP_ASSERT_SVH
`define PATH_RESAMPLER_FIXED_STEP_ASSERT_SVH

// Same-cycle implication, reset masked
`define PRFS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, reset masked
`define PRFS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- src/prfs_pkg.sv -----
// ---------------------------------------------------------------------------
// prfs_pkg
// Shared widths and the command/status bundles between controller and datapath.
// ---------------------------------------------------------------------------
package prfs_pkg;

   localparam int CoordW   = 32;
   localparam int StepW    = 31;
   localparam int RootW    = 33;
   localparam int RadW     = 66;
   localparam int RemW     = 36;
   localparam int NumW     = 63;
   localparam int DremW    = 34;
   localparam int CntW     = 6;
   localparam logic [CntW-1:0] SqrtIters = 6'd32;
   localparam logic [CntW-1:0] DivIters  = 6'd62;
   localparam logic [StepW-1:0] StepReset = 31'd6554;

   typedef struct packed {
      logic load_wp;
      logic diff_en;
      logic sq_en;
      logic sqrt_init;
      logic sqrt_en;
      logic mul_en;
      logic div_en;
      logic emit_step;
      logic emit_last;
      logic ovf;
   } cmd_type;

   typedef struct packed {
      logic new_path;
      logic sqrt_done;
      logic div_done;
      logic dist_gt_step;
      logic out_free;
   } status_type;

endpackage

// ----- src/prfs_ctrl.sv -----
// ---------------------------------------------------------------------------
// prfs_ctrl
// Sequencer: walks each segment through difference, squares, root, compare, multiply, divide, emit.
// ---------------------------------------------------------------------------
module prfs_ctrl #(
   parameter int MAX_POINTS = 64
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_fire,
   output logic                 req_ready,
   input  prfs_pkg::status_type sts,
   output prfs_pkg::cmd_type    cmd
);

   localparam int KW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
   localparam logic [KW-1:0] KLast = KW'(MAX_POINTS - 1);

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_DIFF  = 4'd1;
   localparam logic [3:0] S_SQ    = 4'd2;
   localparam logic [3:0] S_SQI   = 4'd3;
   localparam logic [3:0] S_SQRT  = 4'd4;
   localparam logic [3:0] S_CMP   = 4'd5;
   localparam logic [3:0] S_MUL   = 4'd6;
   localparam logic [3:0] S_DIV   = 4'd7;
   localparam logic [3:0] S_STEP  = 4'd8;
   localparam logic [3:0] S_LAST  = 4'd9;

   logic [3:0]    state_ff, state_in;
   logic [KW-1:0] k_ff, k_in;
   logic          ovf_ff, ovf_in;

   assign req_ready = (state_ff == S_IDLE);

   // next state and command decode
   always_comb begin
      state_in = state_ff;
      k_in     = k_ff;
      ovf_in   = ovf_ff;
      cmd      = '0;
      cmd.ovf  = ovf_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               cmd.load_wp = 1'b1;
               k_in        = '0;
               ovf_in      = 1'b0;
               state_in    = S_DIFF;
            end
         end
         S_DIFF: begin
            // a fresh path emits the waypoint alone
            if (sts.new_path) begin
               state_in = S_LAST;
            end else begin
               cmd.diff_en = 1'b1;
               state_in    = S_SQ;
            end
         end
         S_SQ: begin
            cmd.sq_en = 1'b1;
            state_in  = S_SQI;
         end
         S_SQI: begin
            cmd.sqrt_init = 1'b1;
            state_in      = S_SQRT;
         end
         S_SQRT: begin
            cmd.sqrt_en = 1'b1;
            if (sts.sqrt_done) state_in = S_CMP;
         end
         S_CMP: begin
            priority if (!sts.dist_gt_step) begin
               state_in = S_LAST;
            end else if (k_ff == KLast) begin
               ovf_in   = 1'b1;
               state_in = S_LAST;
            end else begin
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            cmd.mul_en = 1'b1;
            state_in   = S_DIV;
         end
         S_DIV: begin
            cmd.div_en = 1'b1;
            if (sts.div_done) state_in = S_STEP;
         end
         S_STEP: begin
            // hold until the output register frees up
            if (sts.out_free) begin
               cmd.emit_step = 1'b1;
               k_in          = k_ff + KW'(1);
               state_in      = S_DIFF;
            end
         end
         S_LAST: begin
            if (sts.out_free) begin
               cmd.emit_last = 1'b1;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         k_ff     <= '0;
         ovf_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         k_ff     <= k_in;
         ovf_ff   <= ovf_in;
      end
   end

endmodule

// ----- src/prfs_dp.sv -----
// ---------------------------------------------------------------------------
// prfs_dp
// Datapath: current point, squares, bit-serial root and two serial dividers.
// ---------------------------------------------------------------------------
module prfs_dp (
   input  logic                 clock,
   input  logic                 reset,
   input  prfs_pkg::cmd_type    cmd,
   output prfs_pkg::status_type sts,
   input  logic                 csr_wr_en,
   input  logic [30:0]          csr_wr_data,
   input  logic [31:0]          wp_x,
   input  logic [31:0]          wp_y,
   input  logic [31:0]          wp_tag,
   input  logic                 wp_start,
   output logic                 out_valid,
   input  logic                 out_ready,
   output logic [31:0]          out_x,
   output logic [31:0]          out_y,
   output logic [31:0]          out_tag,
   output logic                 out_last,
   output logic                 out_ovf
);

   localparam int CW = prfs_pkg::CoordW;

   // control state
   logic [prfs_pkg::StepW-1:0] step_ff, step_in;
   logic                       open_ff, open_in;
   logic                       vld_ff, vld_in;
   logic [prfs_pkg::CntW-1:0]  cnt_ff, cnt_in;

   // payload state
   logic [CW-1:0] nx_ff, nx_in, ny_ff, ny_in, ntag_ff, ntag_in;
   logic          nstart_ff, nstart_in;
   logic [CW-1:0] cx_ff, cx_in, cy_ff, cy_in, ctag_ff, ctag_in;
   logic [CW-1:0] ax_ff, ax_in, ay_ff, ay_in;
   logic          sx_ff, sx_in, sy_ff, sy_in;
   logic [2*CW-1:0] s1_ff, s1_in, s2_ff, s2_in;
   logic [prfs_pkg::RadW-1:0]  rad_ff, rad_in;
   logic [prfs_pkg::RemW-1:0]  rem_ff, rem_in;
   logic [prfs_pkg::RootW-1:0] root_ff, root_in;
   logic [prfs_pkg::NumW-1:0]  qx_ff, qx_in, qy_ff, qy_in;
   logic [prfs_pkg::DremW-1:0] rx_ff, rx_in, ry_ff, ry_in;
   logic [CW-1:0] ox_ff, ox_in, oy_ff, oy_in, otag_ff, otag_in;
   logic          olast_ff, olast_in, oovf_ff, oovf_in;

   // combinational helpers
   logic [CW:0]                dx, dy, ndx, ndy;
   logic [prfs_pkg::RemW-1:0]  rem_sh, trial;
   logic [prfs_pkg::DremW-1:0] rx_sh, ry_sh, dvs;
   logic [CW-1:0]              new_x, new_y;
   logic                       out_free;

   assign out_free = !vld_ff || out_ready;

   // signed differences and magnitudes
   assign dx  = {nx_ff[CW-1], nx_ff} - {cx_ff[CW-1], cx_ff};
   assign dy  = {ny_ff[CW-1], ny_ff} - {cy_ff[CW-1], cy_ff};
   assign ndx = -dx;
   assign ndy = -dy;

   // one root bit per cycle
   assign rem_sh = {rem_ff[prfs_pkg::RemW-3:0], rad_ff[prfs_pkg::RadW-1 -: 2]};
   assign trial  = {1'b0, root_ff, 2'b01};

   // one quotient bit per cycle on each axis
   assign dvs   = {1'b0, root_ff};
   assign rx_sh = {rx_ff[prfs_pkg::DremW-2:0], qx_ff[prfs_pkg::NumW-1]};
   assign ry_sh = {ry_ff[prfs_pkg::DremW-2:0], qy_ff[prfs_pkg::NumW-1]};

   // step point, always between current point and waypoint
   assign new_x = sx_ff ? cx_ff - qx_ff[CW-1:0] : cx_ff + qx_ff[CW-1:0];
   assign new_y = sy_ff ? cy_ff - qy_ff[CW-1:0] : cy_ff + qy_ff[CW-1:0];

   always_comb begin
      step_in = step_ff;   open_in = open_ff;   vld_in = vld_ff;   cnt_in = cnt_ff;
      nx_in = nx_ff;   ny_in = ny_ff;   ntag_in = ntag_ff;   nstart_in = nstart_ff;
      cx_in = cx_ff;   cy_in = cy_ff;   ctag_in = ctag_ff;
      ax_in = ax_ff;   ay_in = ay_ff;   sx_in = sx_ff;   sy_in = sy_ff;
      s1_in = s1_ff;   s2_in = s2_ff;
      rad_in = rad_ff; rem_in = rem_ff; root_in = root_ff;
      qx_in = qx_ff;   qy_in = qy_ff;   rx_in = rx_ff;   ry_in = ry_ff;
      ox_in = ox_ff;   oy_in = oy_ff;   otag_in = otag_ff;
      olast_in = olast_ff;  oovf_in = oovf_ff;

      if (csr_wr_en) step_in = csr_wr_data;
      if (vld_ff && out_ready) vld_in = 1'b0;

      // capture the request
      if (cmd.load_wp) begin
         nx_in = wp_x;  ny_in = wp_y;  ntag_in = wp_tag;  nstart_in = wp_start;
      end
      if (cmd.diff_en) begin
         sx_in = dx[CW];
         sy_in = dy[CW];
         ax_in = dx[CW] ? ndx[CW-1:0] : dx[CW-1:0];
         ay_in = dy[CW] ? ndy[CW-1:0] : dy[CW-1:0];
      end
      if (cmd.sq_en) begin
         s1_in = ax_ff * ax_ff;
         s2_in = ay_ff * ay_ff;
      end
      if (cmd.sqrt_init) begin
         rad_in  = {1'b0, {1'b0, s1_ff} + {1'b0, s2_ff}};
         rem_in  = '0;
         root_in = '0;
         cnt_in  = prfs_pkg::SqrtIters;
      end
      if (cmd.sqrt_en) begin
         rad_in = {rad_ff[prfs_pkg::RadW-3:0], 2'b00};
         if (rem_sh >= trial) begin
            rem_in  = rem_sh - trial;
            root_in = {root_ff[prfs_pkg::RootW-2:0], 1'b1};
         end else begin
            rem_in  = rem_sh;
            root_in = {root_ff[prfs_pkg::RootW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - prfs_pkg::CntW'(1);
      end
      if (cmd.mul_en) begin
         qx_in  = step_ff * ax_ff;
         qy_in  = step_ff * ay_ff;
         rx_in  = '0;
         ry_in  = '0;
         cnt_in = prfs_pkg::DivIters;
      end
      if (cmd.div_en) begin
         if (rx_sh >= dvs) begin
            rx_in = rx_sh - dvs;
            qx_in = {qx_ff[prfs_pkg::NumW-2:0], 1'b1};
         end else begin
            rx_in = rx_sh;
            qx_in = {qx_ff[prfs_pkg::NumW-2:0], 1'b0};
         end
         if (ry_sh >= dvs) begin
            ry_in = ry_sh - dvs;
            qy_in = {qy_ff[prfs_pkg::NumW-2:0], 1'b1};
         end else begin
            ry_in = ry_sh;
            qy_in = {qy_ff[prfs_pkg::NumW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - prfs_pkg::CntW'(1);
      end
      // emit a step point, keeping the old tag
      if (cmd.emit_step) begin
         cx_in = new_x;  cy_in = new_y;
         ox_in = new_x;  oy_in = new_y;  otag_in = ctag_ff;
         olast_in = 1'b0;  oovf_in = 1'b0;  vld_in = 1'b1;
      end
      // emit the waypoint and make it current
      if (cmd.emit_last) begin
         cx_in = nx_ff;  cy_in = ny_ff;  ctag_in = ntag_ff;  open_in = 1'b1;
         ox_in = nx_ff;  oy_in = ny_ff;  otag_in = ntag_ff;
         olast_in = 1'b1;  oovf_in = cmd.ovf;  vld_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= prfs_pkg::StepReset;
         open_ff <= 1'b0;
         vld_ff  <= 1'b0;
         cnt_ff  <= '0;
         cx_ff   <= '0;
         cy_ff   <= '0;
         ctag_ff <= '0;
      end else begin
         step_ff <= step_in;
         open_ff <= open_in;
         vld_ff  <= vld_in;
         cnt_ff  <= cnt_in;
         cx_ff   <= cx_in;
         cy_ff   <= cy_in;
         ctag_ff <= ctag_in;
      end
   end

   always_ff @(posedge clock) begin
      nx_ff <= nx_in;  ny_ff <= ny_in;  ntag_ff <= ntag_in;  nstart_ff <= nstart_in;
      ax_ff <= ax_in;  ay_ff <= ay_in;  sx_ff <= sx_in;  sy_ff <= sy_in;
      s1_ff <= s1_in;  s2_ff <= s2_in;
      rad_ff <= rad_in;  rem_ff <= rem_in;  root_ff <= root_in;
      qx_ff <= qx_in;  qy_ff <= qy_in;  rx_ff <= rx_in;  ry_ff <= ry_in;
      ox_ff <= ox_in;  oy_ff <= oy_in;  otag_ff <= otag_in;
      olast_ff <= olast_in;  oovf_ff <= oovf_in;
   end

   assign sts.new_path     = nstart_ff || !open_ff;
   assign sts.sqrt_done    = (cnt_ff == '0);
   assign sts.div_done     = (cnt_ff == '0);
   assign sts.dist_gt_step = (root_ff > {2'b00, step_ff});
   assign sts.out_free     = out_free;

   assign out_valid = vld_ff;
   assign out_x     = ox_ff;
   assign out_y     = oy_ff;
   assign out_tag   = otag_ff;
   assign out_last  = olast_ff;
   assign out_ovf   = oovf_ff;

endmodule

// ----- src/path_resampler_fixed_step.sv -----
// ---------------------------------------------------------------------------
// path_resampler_fixed_step
// Resamples planar waypoints into points spaced a fixed step apart.
// ---------------------------------------------------------------------------
// Usage:
//   req_* carries one waypoint per request: tdata = {heading_tag, pos_y, pos_x}
//   (pos_x lowest), tuser = path_start. rsp_* returns points: tdata =
//   {out_tag, out_y, out_x}, tlast = last_point, tuser = step_overflow.
//   csr_wr_en/csr_wr_data write step_length; write only while idle.
// Sequence:
//   A waypoint that opens a path goes straight to its emit and gives a single
//   point. Each step point takes difference, squares, a bit-serial square
//   root, compare, multiply and a bit-serial divide (both axes in parallel),
//   then the emit; the closing point follows a fresh difference, squares,
//   root and compare. One waypoint is worked at a time; req_tready rises again
//   once its final point is loaded, so a waypoint gives up to 64 points.
// Reset:
//   Clears the current point, tag and open-path flag; step_length returns to
//   6554. No clearing pass is needed.
// Stall:
//   A single output register holds each point; while it is full and
//   rsp_tready is low the sequencer waits at its emit step and no work is lost.
// ---------------------------------------------------------------------------
`include "path_resampler_fixed_step_assert.svh"

module path_resampler_fixed_step #(
   parameter int MAX_POINTS = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [95:0] req_tdata,   // pos_x, pos_y, heading_tag
   input  logic        req_tuser,   // path_start
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [95:0] rsp_tdata,   // out_x, out_y, out_tag
   output logic        rsp_tlast,   // last_point
   output logic        rsp_tuser,   // step_overflow
   input  logic        csr_wr_en,
   input  logic [30:0] csr_wr_data
);

   prfs_pkg::cmd_type    cmd;
   prfs_pkg::status_type sts;
   logic                 req_fire;

   assign req_fire = req_tvalid && req_tready;

   prfs_ctrl #(.MAX_POINTS(MAX_POINTS)) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_fire  (req_fire),
      .req_ready (req_tready),
      .sts       (sts),
      .cmd       (cmd)
   );

   prfs_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .sts         (sts),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .wp_x        (req_tdata[31:0]),
      .wp_y        (req_tdata[63:32]),
      .wp_tag      (req_tdata[95:64]),
      .wp_start    (req_tuser),
      .out_valid   (rsp_tvalid),
      .out_ready   (rsp_tready),
      .out_x       (rsp_tdata[31:0]),
      .out_y       (rsp_tdata[63:32]),
      .out_tag     (rsp_tdata[95:64]),
      .out_last    (rsp_tlast),
      .out_ovf     (rsp_tuser)
   );

   // one waypoint in flight at a time
   `PRFS_ASSERT_NEXT(a_one_request, clock, reset, req_fire, !req_tready, "second request taken while busy")
   // overflow only ever marks the closing point
   `PRFS_ASSERT_NOW(a_ovf_last, clock, reset, rsp_tvalid && rsp_tuser, rsp_tlast, "overflow on a step point")
   // emit only into a free output register
   `PRFS_ASSERT_NOW(a_emit_free, clock, reset, cmd.emit_step || cmd.emit_last, sts.out_free, "emit into a full output register")

endmodule
